// ----- hdl/mbd_pkg.sv -----
// Shared types, constants and helpers of the mask boundary detector.
package mbd_pkg;

	localparam int MAX_WIDTH    = 1024;
	localparam int MAX_HEIGHT   = 4096;
	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int ROW_W        = $clog2(MAX_HEIGHT);
	localparam int WIDTH_CFG_W  = 11;
	localparam int HEIGHT_CFG_W = 13;
	localparam int CFG_DATA_W   = 13;
	localparam int CFG_INDEX_W  = 4;
	localparam int FIFO_DEPTH   = 3;
	localparam int FIFO_CNT_W   = 2;
	localparam int FIFO_PTR_W   = 2;

	localparam logic [7:0] PIX_WHITE  = 8'd255;
	localparam logic [7:0] PIX_BLACK  = 8'd0;
	localparam logic       KIND_PIXEL = 1'b0;
	localparam logic       KIND_FLUSH = 1'b1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_IMAGE_WIDTH  = 4'd0,
		REG_IMAGE_HEIGHT = 4'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CLS_OTHER = 2'd0,
		CLS_BLACK = 2'd1,
		CLS_WHITE = 2'd2
	} pix_class_t;

	typedef struct packed {
		logic             en;
		logic [COL_W-1:0] addr;
		pix_class_t       code;
	} line_req_t;

	typedef struct packed {
		pix_class_t top;
		pix_class_t mid;
	} line_rd_t;

	typedef struct packed {
		logic [7:0]       boundary_value;
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] row;
		logic             frame_end;
	} res_t;

	function automatic pix_class_t classify(input logic [7:0] value);
		pix_class_t cls;
		if (value == PIX_WHITE) begin
			cls = CLS_WHITE;
		end else if (value == PIX_BLACK) begin
			cls = CLS_BLACK;
		end else begin
			cls = CLS_OTHER;
		end
		return cls;
	endfunction

endpackage

// ----- hdl/mbd_if.sv -----
// Handshake channels of the mask boundary detector: pixels, results and configuration.
interface mbd_pix_if;
	import mbd_pkg::*;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] mask_value;
	modport source (output valid, output kind, output mask_value, input ready);
	modport sink (input valid, input kind, input mask_value, output ready);
endinterface

interface mbd_res_if;
	import mbd_pkg::*;
	logic             valid;
	logic             ready;
	logic [7:0]       boundary_value;
	logic [COL_W-1:0] column;
	logic [ROW_W-1:0] row;
	logic             frame_end;
	modport source (output valid, output boundary_value, output column, output row,
		output frame_end, input ready);
	modport sink (input valid, input boundary_value, input column, input row,
		input frame_end, output ready);
endinterface

interface mbd_cfg_if;
	import mbd_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/mbd_line_store.sv -----
// Two-row line store in one synchronous memory, read-modify-write with forwarding.
module mbd_line_store (
	input  logic               clk,
	input  logic               arst_n,
	input  mbd_pkg::line_req_t req,
	output mbd_pkg::line_rd_t  rd
);
	import mbd_pkg::*;

	line_rd_t         mem [MAX_WIDTH];
	line_rd_t         rd_data_s1;
	line_rd_t         fwd_data_s1;
	line_rd_t         wr_data;
	logic             en_s1;
	logic             fwd_s1;
	logic [COL_W-1:0] addr_s1;
	pix_class_t       code_s1;

	// With a one-pixel row every item hits the same entry, so the read issued
	// while the previous item writes back takes the write data instead.
	assign rd      = fwd_s1 ? fwd_data_s1 : rd_data_s1;
	assign wr_data = '{top: rd.mid, mid: code_s1};

	always_ff @(posedge clk) begin
		if (req.en) begin
			rd_data_s1 <= mem[req.addr];
		end
		if (en_s1) begin
			mem[addr_s1] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1     <= req.addr;
		code_s1     <= req.code;
		fwd_data_s1 <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1  <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			en_s1  <= req.en;
			fwd_s1 <= req.en && en_s1 && (req.addr == addr_s1);
		end
	end

endmodule

// ----- hdl/mbd_out_fifo.sv -----
// Three-entry result queue that decouples the pipeline from the result channel.
module mbd_out_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  mbd_pkg::res_t                 push_item,
	input  logic                          pop,
	output logic                          out_valid,
	output mbd_pkg::res_t                 out_item,
	output logic [mbd_pkg::FIFO_CNT_W-1:0] count
);
	import mbd_pkg::*;

	res_t                  entries [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  do_pop;

	assign out_valid = count_q != '0;
	assign out_item  = entries[rd_ptr_q];
	assign count     = count_q;
	assign do_pop    = pop && out_valid;

	function automatic logic [FIFO_PTR_W-1:0] ptr_next(input logic [FIFO_PTR_W-1:0] p);
		logic [FIFO_PTR_W-1:0] n;
		if (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + 1'b1;
		end
		return n;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entries[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hdl/mask_boundary_detect.sv -----
// Inner boundary of a binary mask (4-connected) on a raster pixel stream. The block takes one
// item per clock cycle without pause while results are taken: an item is accepted at raster
// position (r, c), the two rows above it are read from a single line memory in that cycle, and
// in the next cycle the memory is written back and the 3x3 neighbourhood is evaluated, so the
// memory port sets the rate of one item per cycle. The result for pixel (r, c) leaves in
// response to the item at (r+1, c+1), or (r+2, 0) for the last column. It appears on the result
// channel after the evaluation stage has pushed it into the queue. A three-item queue absorbs
// short stalls of the result channel; a longer stall holds off the input once the queue and
// the stage in front of it together hold three results. After the last pixel of a frame,
// width+1 flush items drain the remaining results; a flush item at the start of a frame is
// dropped. Neighbours outside the frame count as white. The line memory has no clearing pass
// after reset: no result depends on an entry that the current frame has not written. Writing
// either register restarts the frame.
module mask_boundary_detect (
	input  logic  clk,
	input  logic  arst_n,
	mbd_cfg_if.sink   cfg,
	mbd_pix_if.sink   pix,
	mbd_res_if.source res
);
	import mbd_pkg::*;

	typedef struct packed {
		pix_class_t       code;
		logic [COL_W-1:0] cc;
		logic [ROW_W-1:0] cr;
		logic             at_left;
		logic             at_right;
		logic             at_top;
		logic             at_bottom;
		logic             last;
	} s1_item_t;

	logic [COL_W-1:0]      last_col_q;
	logic [ROW_W-1:0]      last_row_q;
	logic [COL_W-1:0]      in_col_q;
	logic [ROW_W:0]        in_row_q;
	logic [COL_W-1:0]      cfg_last_col;
	logic [ROW_W-1:0]      cfg_last_row;
	logic [WIDTH_CFG_W-1:0]  cfg_width;
	logic [HEIGHT_CFG_W-1:0] cfg_height;
	logic                  cfg_wr;

	logic                  pix_acc;
	logic                  acc;
	logic                  acc_res_v;
	logic                  acc_last;
	logic [ROW_W:0]        acc_cr;
	logic [COL_W-1:0]      acc_cc;
	pix_class_t            acc_code;
	logic [COL_W:0]        col_inc;
	logic [COL_W-1:0]      next_col;
	logic [ROW_W:0]        next_row;

	logic                  valid_s1;
	logic                  res_v_s1;
	s1_item_t              item_s1;
	line_req_t             line_req;
	line_rd_t              line_rd;

	pix_class_t            win_top_q;
	pix_class_t            win_mid_q;
	pix_class_t            win_cur_q;
	pix_class_t            win_lmid_q;
	pix_class_t            nb_left;
	pix_class_t            nb_right;
	pix_class_t            nb_up;
	pix_class_t            nb_down;
	logic                  is_edge;

	res_t                  push_item;
	logic                  push;
	logic [FIFO_CNT_W-1:0] fifo_cnt;
	logic                  fifo_valid;
	res_t                  fifo_item;

	// Configuration: stored as last column / last row after clamping
	assign cfg.ready  = 1'b1;
	assign cfg_wr     = cfg.valid && cfg.ready &&
		((cfg.index == REG_IMAGE_WIDTH) || (cfg.index == REG_IMAGE_HEIGHT));
	assign cfg_width  = cfg.data[WIDTH_CFG_W-1:0];
	assign cfg_height = cfg.data[HEIGHT_CFG_W-1:0];

	always_comb begin
		if (cfg_width == '0) begin
			cfg_last_col = '0;
		end else if (cfg_width > WIDTH_CFG_W'(MAX_WIDTH)) begin
			cfg_last_col = COL_W'(MAX_WIDTH - 1);
		end else begin
			cfg_last_col = COL_W'(cfg_width - 1'b1);
		end
		if (cfg_height == '0) begin
			cfg_last_row = '0;
		end else if (cfg_height > HEIGHT_CFG_W'(MAX_HEIGHT)) begin
			cfg_last_row = ROW_W'(MAX_HEIGHT - 1);
		end else begin
			cfg_last_row = ROW_W'(cfg_height - 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_col_q <= COL_W'(639);
			last_row_q <= ROW_W'(479);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_IMAGE_WIDTH:  last_col_q <= cfg_last_col;
				REG_IMAGE_HEIGHT: last_row_q <= cfg_last_row;
				default: ;
			endcase
		end
	end

	// Accept stage: classify the pixel, work out which pixel's result it completes
	assign pix.ready = ({1'b0, fifo_cnt} + {{FIFO_CNT_W{1'b0}}, res_v_s1}) <
		(FIFO_CNT_W + 1)'(FIFO_DEPTH);
	assign pix_acc   = pix.valid && pix.ready;
	assign acc       = pix_acc &&
		!((pix.kind == KIND_FLUSH) && (in_col_q == '0) && (in_row_q == '0));

	always_comb begin
		if ((pix.kind == KIND_PIXEL) && (in_row_q <= {1'b0, last_row_q})) begin
			acc_code = classify(pix.mask_value);
		end else begin
			acc_code = CLS_OTHER;
		end
		if (in_col_q == '0) begin
			acc_res_v = in_row_q >= (ROW_W + 1)'(2);
			acc_cr    = in_row_q - (ROW_W + 1)'(2);
			acc_cc    = last_col_q;
		end else begin
			acc_res_v = in_row_q != '0;
			acc_cr    = in_row_q - 1'b1;
			acc_cc    = in_col_q - 1'b1;
		end
		acc_res_v = acc_res_v && (acc_cr <= {1'b0, last_row_q});
		acc_last  = acc_res_v && (acc_cr == {1'b0, last_row_q}) && (acc_cc == last_col_q);
		col_inc   = {1'b0, in_col_q} + 1'b1;
		if (col_inc > {1'b0, last_col_q}) begin
			next_col = '0;
			next_row = in_row_q + 1'b1;
		end else begin
			next_col = col_inc[COL_W-1:0];
			next_row = in_row_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q <= '0;
			in_row_q <= '0;
		end else if (cfg_wr || (acc && acc_last)) begin
			in_col_q <= '0;
			in_row_q <= '0;
		end else if (acc) begin
			in_col_q <= next_col;
			in_row_q <= next_row;
		end
	end

	assign line_req = '{en: acc, addr: in_col_q, code: acc_code};

	mbd_line_store u_line_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (line_req),
		.rd     (line_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			res_v_s1 <= 1'b0;
		end else begin
			valid_s1 <= acc;
			res_v_s1 <= acc && acc_res_v;
		end
	end

	always_ff @(posedge clk) begin
		item_s1.code      <= acc_code;
		item_s1.cc        <= acc_cc;
		item_s1.cr        <= acc_cr[ROW_W-1:0];
		item_s1.at_left   <= acc_cc == '0;
		item_s1.at_right  <= acc_cc == last_col_q;
		item_s1.at_top    <= acc_cr == '0;
		item_s1.at_bottom <= acc_cr == {1'b0, last_row_q};
		item_s1.last      <= acc_last;
	end

	// Evaluation stage: the window holds the newest column (rows r-2, r-1, r) and the
	// middle row of the column before it; the freshly read column supplies the right neighbour.
	always_comb begin
		nb_left  = item_s1.at_left   ? CLS_WHITE : win_lmid_q;
		nb_right = item_s1.at_right  ? CLS_WHITE : line_rd.mid;
		nb_up    = item_s1.at_top    ? CLS_WHITE : win_top_q;
		nb_down  = item_s1.at_bottom ? CLS_WHITE : win_cur_q;
		is_edge  = (win_mid_q == CLS_WHITE) &&
			((nb_left == CLS_BLACK) || (nb_right == CLS_BLACK) ||
			 (nb_up == CLS_BLACK) || (nb_down == CLS_BLACK));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_top_q  <= CLS_WHITE;
			win_mid_q  <= CLS_WHITE;
			win_cur_q  <= CLS_WHITE;
			win_lmid_q <= CLS_WHITE;
		end else if (cfg_wr || (valid_s1 && item_s1.last)) begin
			win_top_q  <= CLS_WHITE;
			win_mid_q  <= CLS_WHITE;
			win_cur_q  <= CLS_WHITE;
			win_lmid_q <= CLS_WHITE;
		end else if (valid_s1) begin
			win_lmid_q <= win_mid_q;
			win_top_q  <= line_rd.top;
			win_mid_q  <= line_rd.mid;
			win_cur_q  <= item_s1.code;
		end
	end

	assign push      = valid_s1 && res_v_s1;
	assign push_item = '{
		boundary_value: is_edge ? PIX_WHITE : PIX_BLACK,
		column:         item_s1.cc,
		row:            item_s1.cr,
		frame_end:      item_s1.last
	};

	mbd_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (res.ready),
		.out_valid (fifo_valid),
		.out_item  (fifo_item),
		.count     (fifo_cnt)
	);

	assign res.valid          = fifo_valid;
	assign res.boundary_value = fifo_item.boundary_value;
	assign res.column         = fifo_item.column;
	assign res.row            = fifo_item.row;
	assign res.frame_end      = fifo_item.frame_end;

	// The input credit check must leave room for every result still in flight.
	a_no_fifo_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (fifo_cnt != FIFO_CNT_W'(FIFO_DEPTH)))
		else $error("result queue overflow");

	a_restart_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && acc_last) |=> ((in_col_q == '0) && (in_row_q == '0)))
		else $error("frame position not cleared after last pixel");

	a_column_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		in_col_q <= last_col_q)
		else $error("input column beyond row width");

	a_last_item_restarts_window: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && item_s1.last) |=> ((win_mid_q == CLS_WHITE) && (win_lmid_q == CLS_WHITE)))
		else $error("window not reset after frame end");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the mask boundary detector: directed frame, extreme sizes, random frames.
module tb_top;
	import mbd_pkg::*;

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 11;
	localparam int DEFAULT_WIDTH = 640;
	localparam int RANDOM_ITEMS  = 700;
	localparam int CLAMP_ITEMS   = 40;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 400;
	localparam logic [CFG_INDEX_W-1:0] FIRST_SPARE_REG = CFG_INDEX_W'(REG_IMAGE_HEIGHT + 1);
	localparam logic [CFG_INDEX_W-1:0] LAST_SPARE_REG  = '1;

	typedef enum {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_MOSTLY} sink_mode_t;

	typedef struct {
		logic       kind;
		logic [7:0] value;
		bit         typed;
		res_t       want;
	} stim_row_t;

	// A 4 x 3 frame. Results for pixels on the frame edge are typed in; the two inner
	// pixels are left to the predictor.
	stim_row_t directed_rows [19] = '{
		'{KIND_FLUSH, 8'd0,   1'b0, '0},
		'{KIND_PIXEL, 8'd255, 1'b0, '0},
		'{KIND_PIXEL, 8'd255, 1'b0, '0},
		'{KIND_PIXEL, 8'd0,   1'b0, '0},
		'{KIND_PIXEL, 8'd255, 1'b0, '0},
		'{KIND_PIXEL, 8'd255, 1'b0, '0},
		'{KIND_PIXEL, 8'd254, 1'b1, '{PIX_BLACK, 10'd0, 12'd0, 1'b0}},
		'{KIND_PIXEL, 8'd255, 1'b1, '{PIX_WHITE, 10'd1, 12'd0, 1'b0}},
		'{KIND_PIXEL, 8'd255, 1'b1, '{PIX_BLACK, 10'd2, 12'd0, 1'b0}},
		'{KIND_FLUSH, 8'd255, 1'b1, '{PIX_WHITE, 10'd3, 12'd0, 1'b0}},
		'{KIND_PIXEL, 8'd255, 1'b1, '{PIX_BLACK, 10'd0, 12'd1, 1'b0}},
		'{KIND_PIXEL, 8'd255, 1'b0, '0},
		'{KIND_PIXEL, 8'd0,   1'b0, '0},
		'{KIND_FLUSH, 8'd0,   1'b1, '{PIX_WHITE, 10'd3, 12'd1, 1'b0}},
		'{KIND_PIXEL, 8'd0,   1'b1, '{PIX_BLACK, 10'd0, 12'd2, 1'b0}},
		'{KIND_FLUSH, 8'hA5,  1'b1, '{PIX_BLACK, 10'd1, 12'd2, 1'b0}},
		'{KIND_FLUSH, 8'd0,   1'b1, '{PIX_WHITE, 10'd2, 12'd2, 1'b0}},
		'{KIND_PIXEL, 8'd0,   1'b1, '{PIX_BLACK, 10'd3, 12'd2, 1'b1}},
		'{KIND_FLUSH, 8'd0,   1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n;

	mbd_cfg_if cfg_ch ();
	mbd_pix_if pix_ch ();
	mbd_res_if res_ch ();

	mask_boundary_detect u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.pix    (pix_ch),
		.res    (res_ch)
	);

	// Predictor state: line stores, 3x3 neighbourhood, raster position and geometry.
	pix_class_t  upper_mem [MAX_WIDTH];
	pix_class_t  middle_mem [MAX_WIDTH];
	pix_class_t  nbhd [9];
	int unsigned pos_col, pos_row;
	int unsigned cfg_width  = DEFAULT_WIDTH;
	int unsigned cfg_height = 480;

	res_t        boundary_q [$];
	int unsigned mismatch_count, results_checked, boundary_hits, items_accepted, frame_items;
	int unsigned frames_done, geometry_changes, regs_written, long_holds;
	int unsigned burst_left, gap_left;

	always #CLK_HALF clk = ~clk;

	function automatic int unsigned effective_dim(input int unsigned v, input int unsigned hi);
		return (v < 1) ? 1 : (v > hi) ? hi : v;
	endfunction

	function automatic void reset_frame_position();
		for (int i = 0; i < 9; i++) nbhd[i] = CLS_WHITE;
		pos_col = 0;
		pos_row = 0;
	endfunction

	// Advances the predictor by one item; returns 1 when the item releases a result.
	function automatic bit predict_boundary(input logic item_kind, input logic [7:0] item_value,
			output res_t outcome);
		int unsigned w, h, pc, pr, cr, cc;
		pix_class_t cls, above, here, lft, rgt, upn, dwn;
		bit fire, last;
		outcome = '0;
		w = effective_dim(cfg_width, MAX_WIDTH);
		h = effective_dim(cfg_height, MAX_HEIGHT);
		if (item_kind == KIND_FLUSH && pos_col == 0 && pos_row == 0) begin
			return 1'b0;
		end
		frame_items++;
		pc = (pos_col >= w) ? w - 1 : pos_col;
		pr = pos_row;
		cls = CLS_OTHER;
		if (item_kind == KIND_PIXEL && pr < h) begin
			cls = (item_value == PIX_WHITE) ? CLS_WHITE :
				(item_value == PIX_BLACK) ? CLS_BLACK : CLS_OTHER;
		end
		above = upper_mem[pc];
		here = middle_mem[pc];
		upper_mem[pc] = here;
		middle_mem[pc] = cls;
		for (int i = 0; i < 6; i++) nbhd[i] = nbhd[i+3];
		nbhd[6] = above;
		nbhd[7] = here;
		nbhd[8] = cls;
		// The first column closes the last pixel of the row two back.
		if (pc == 0) begin
			fire = pr >= 2;
			cr = fire ? pr - 2 : 0;
			cc = w - 1;
		end else begin
			fire = pr >= 1;
			cr = fire ? pr - 1 : 0;
			cc = pc - 1;
		end
		last = 1'b0;
		if (fire && cr < h) begin
			lft = (cc == 0) ? CLS_WHITE : nbhd[1];
			rgt = (cc == w - 1) ? CLS_WHITE : nbhd[7];
			upn = (cr == 0) ? CLS_WHITE : nbhd[3];
			dwn = (cr == h - 1) ? CLS_WHITE : nbhd[5];
			last = (cr == h - 1) && (cc == w - 1);
			outcome.boundary_value = (nbhd[4] == CLS_WHITE && (lft == CLS_BLACK ||
				rgt == CLS_BLACK || upn == CLS_BLACK || dwn == CLS_BLACK)) ?
				PIX_WHITE : PIX_BLACK;
			outcome.column = cc[COL_W-1:0];
			outcome.row = cr[ROW_W-1:0];
			outcome.frame_end = last;
		end else begin
			fire = 1'b0;
		end
		if (last) begin
			reset_frame_position();
		end else begin
			pc++;
			if (pc >= w) begin
				pc = 0;
				pr++;
			end
			pos_col = pc;
			pos_row = pr;
		end
		return fire;
	endfunction

	function automatic void random_pixel(output logic item_kind, output logic [7:0] item_value);
		int unsigned pick;
		pick = $urandom_range(0, 99);
		item_kind = KIND_PIXEL;
		item_value = 8'($urandom());
		if (pick < 44) begin
			item_value = PIX_WHITE;
		end else if (pick < 84) begin
			item_value = PIX_BLACK;
		end else if (pick >= 95) begin
			item_kind = KIND_FLUSH;
		end
	endfunction

	// Offers one item in bursts separated by random gaps and predicts on acceptance.
	task automatic send_item(input logic item_kind, input logic [7:0] item_value,
			input bit typed, input res_t want);
		res_t predicted;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) == 0) begin
				burst_left = $urandom_range(50, 300);
				gap_left = 0;
			end else begin
				burst_left = $urandom_range(1, 20);
				gap_left = $urandom_range(1, 8);
			end
		end
		while (gap_left > 0) begin
			@(negedge clk);
			pix_ch.valid <= 1'b0;
			gap_left--;
		end
		@(negedge clk);
		pix_ch.valid <= 1'b1;
		pix_ch.kind <= item_kind;
		pix_ch.mask_value <= item_value;
		do @(posedge clk); while (!pix_ch.ready);
		burst_left--;
		items_accepted++;
		if (predict_boundary(item_kind, item_value, predicted)) begin
			boundary_q.push_back(typed ? want : predicted);
		end
	endtask

	// Stops offering until every outstanding result is back, then lets any dropped
	// items clear the pipeline.
	task automatic pause_sender();
		@(negedge clk);
		pix_ch.valid <= 1'b0;
		burst_left = 0;
		while (boundary_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		regs_written++;
		if (index == REG_IMAGE_WIDTH) begin
			cfg_width = data[WIDTH_CFG_W-1:0];
			reset_frame_position();
		end else if (index == REG_IMAGE_HEIGHT) begin
			cfg_height = data[HEIGHT_CFG_W-1:0];
			reset_frame_position();
		end
	endtask

	task automatic set_geometry(input logic [CFG_DATA_W-1:0] wdata,
			input logic [CFG_DATA_W-1:0] hdata);
		pause_sender();
		write_reg(REG_IMAGE_WIDTH, wdata);
		write_reg(REG_IMAGE_HEIGHT, hdata);
		geometry_changes++;
	endtask

	// A truncated frame stops part-way with no drain; a register write must follow it.
	task automatic send_frame(input bit truncate);
		int unsigned w, h, pixels;
		logic k;
		logic [7:0] v;
		w = effective_dim(cfg_width, MAX_WIDTH);
		h = effective_dim(cfg_height, MAX_HEIGHT);
		pixels = truncate ? $urandom_range(1, w * h) : w * h;
		for (int unsigned i = 0; i < pixels; i++) begin
			random_pixel(k, v);
			send_item(k, v, 1'b0, '0);
		end
		if (!truncate) begin
			for (int unsigned i = 0; i <= w; i++) begin
				if ($urandom_range(0, 6) == 0) begin
					send_item(KIND_PIXEL, 8'($urandom()), 1'b0, '0);
				end else begin
					send_item(KIND_FLUSH, 8'($urandom()), 1'b0, '0);
				end
			end
			frames_done++;
		end
	endtask

	initial begin
		logic k;
		logic [7:0] v;
		bit restart_due;
		int unsigned random_start, w, h, pick;
		arst_n = 1'b0;
		pix_ch.valid = 1'b0;
		pix_ch.kind = KIND_PIXEL;
		pix_ch.mask_value = PIX_BLACK;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_IMAGE_WIDTH;
		cfg_ch.data = '0;
		for (int i = 0; i < MAX_WIDTH; i++) begin
			upper_mem[i] = CLS_OTHER;
			middle_mem[i] = CLS_OTHER;
		end
		reset_frame_position();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Default geometry: a flush at the origin is dropped, then just over one row of
		// pixels proves the reset width before the first register write restarts the frame.
		send_item(KIND_FLUSH, 8'd0, 1'b0, '0);
		for (int i = 0; i < DEFAULT_WIDTH + 3; i++) begin
			random_pixel(k, v);
			send_item(k, v, 1'b0, '0);
		end

		set_geometry(13'd4, 13'd3);
		foreach (directed_rows[i]) begin
			send_item(directed_rows[i].kind, directed_rows[i].value, directed_rows[i].typed,
				directed_rows[i].want);
		end

		// Zero sizes act as one; writes to unused indexes change nothing.
		set_geometry(13'd0, 13'd0);
		send_frame(1'b0);
		pause_sender();
		write_reg(CFG_INDEX_W'($urandom_range(FIRST_SPARE_REG, LAST_SPARE_REG)),
			13'($urandom()));
		send_frame(1'b0);
		set_geometry(13'd1, 13'd1);
		send_frame(1'b0);

		// Oversized registers clamp to the maximum frame, so a short start of a frame
		// stays inside the first row and releases nothing.
		set_geometry(13'h07FF, 13'h1FFF);
		for (int i = 0; i < CLAMP_ITEMS; i++) begin
			random_pixel(k, v);
			send_item(k, v, 1'b0, '0);
		end

		random_start = frame_items;
		restart_due = 1'b1;
		while (frame_items - random_start < RANDOM_ITEMS) begin
			if (restart_due || $urandom_range(0, 2) != 0) begin
				pick = $urandom_range(0, 9);
				w = (pick < 7) ? $urandom_range(1, 12) : (pick < 9) ? $urandom_range(13, 32) : 0;
				pick = $urandom_range(0, 9);
				h = (pick < 7) ? $urandom_range(1, 10) : (pick < 9) ? $urandom_range(11, 20) : 0;
				set_geometry({2'($urandom()), 11'(w)}, 13'(h));
				if ($urandom_range(0, 7) == 0) begin
					write_reg(CFG_INDEX_W'($urandom_range(FIRST_SPARE_REG, LAST_SPARE_REG)),
						13'($urandom()));
				end
			end
			restart_due = $urandom_range(0, 9) == 0;
			send_frame(restart_due);
			if (!restart_due && $urandom_range(0, 3) == 0) begin
				send_item(KIND_FLUSH, 8'($urandom()), 1'b0, '0);
			end
		end

		pause_sender();
		repeat (20) @(posedge clk);
		if (boundary_q.size() != 0) begin
			mismatch_count++;
			$error("%0d expected results never arrived", boundary_q.size());
		end
		$display("Summary: %0d items accepted, %0d results checked, %0d boundary pixels.",
			items_accepted, results_checked, boundary_hits);
		$display("Summary: %0d complete frames, %0d geometries, %0d register writes, %0d long stalls.",
			frames_done, geometry_changes, regs_written, long_holds);
		if (mismatch_count == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

	// Result side: changing stall patterns, with a long hold-off now and then so that
	// the output queue fills and the block stalls its input.
	initial begin
		sink_mode_t mode;
		int unsigned mode_left, hold_left, next_hold, phase;
		res_ch.ready = 1'b0;
		mode = SINK_OPEN;
		mode_left = 0;
		hold_left = 0;
		next_hold = 200;
		phase = 0;
		forever begin
			@(negedge clk);
			if (hold_left == 0 && results_checked >= next_hold) begin
				hold_left = HOLD_CYCLES;
				next_hold += 250;
				long_holds++;
			end
			if (mode_left == 0) begin
				mode = sink_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 150);
			end
			mode_left--;
			phase++;
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				case (mode)
					SINK_OPEN:   res_ch.ready <= 1'b1;
					SINK_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
					SINK_SPARSE: res_ch.ready <= (phase % 4 == 0);
					default:     res_ch.ready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin : result_check
		res_t got, want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = '{res_ch.boundary_value, res_ch.column, res_ch.row, res_ch.frame_end};
			results_checked++;
			if (got.boundary_value == PIX_WHITE) boundary_hits++;
			if (boundary_q.size() == 0) begin
				mismatch_count++;
				$error("unexpected result: row %0d column %0d value %0d", got.row, got.column,
					got.boundary_value);
			end else begin
				want = boundary_q.pop_front();
				if (got.boundary_value !== want.boundary_value) begin
					mismatch_count++;
					$error("boundary_value: expected %0d, got %0d", want.boundary_value,
						got.boundary_value);
				end
				if (got.column !== want.column) begin
					mismatch_count++;
					$error("column: expected %0d, got %0d", want.column, got.column);
				end
				if (got.row !== want.row) begin
					mismatch_count++;
					$error("row: expected %0d, got %0d", want.row, got.row);
				end
				if (got.frame_end !== want.frame_end) begin
					mismatch_count++;
					$error("frame_end: expected %0d, got %0d", want.frame_end, got.frame_end);
				end
			end
		end
	end

	initial begin
		#10ms;
		$display("Timeout with %0d results outstanding.", boundary_q.size());
		$display("tb_top failed");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/mbd_pkg.sv
hdl/mbd_if.sv
hdl/mbd_line_store.sv
hdl/mbd_out_fifo.sv
hdl/mask_boundary_detect.sv
dv/tb_top.sv
